// ----- rtl/oahi_pkg.sv -----
package oahi_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_DUP   = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  localparam logic [1:0] CFG_SLOT_COUNT = 2'd0;
  localparam logic [1:0] CFG_HASH_SEED  = 2'd1;

  localparam logic [7:0] SLOT_COUNT_RST = 8'd255;
  localparam logic [7:0] HASH_SEED_RST  = 8'd1;
  localparam logic [7:0] PROBE_STEP_RST = 8'd1;

  localparam logic [7:0] STEP_SMALL_MAX = 8'd10;
  localparam logic [7:0] STEP_MID_MAX   = 8'd20;
  localparam logic [7:0] STEP_ODD_A     = 8'd14;
  localparam logic [7:0] STEP_ODD_B     = 8'd18;
  localparam logic [7:0] STEP_ODD_VAL   = 8'd5;
  localparam logic [7:0] DECIMAL_BASE   = 8'd10;

  localparam int SHORT_ITERS = 4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_STEPMOD,
    S_PROBE,
    S_CMP,
    S_RD_WAIT,
    S_GCD_TEST,
    S_GCD
  } state_t;

  typedef struct packed {
    logic       start;
    logic       short_op;
    logic [7:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] rem;
  } mod_rsp_t;

  // v / 10 by reciprocal, exact for 8-bit v
  function automatic logic [7:0] div10(input logic [7:0] v);
    logic [15:0] p;
    p = 16'(v) * 16'd205;
    return 8'(p >> 11);
  endfunction

  function automatic logic is_mult10(input logic [7:0] v);
    logic [7:0]  q;
    logic [11:0] m;
    q = div10(v);
    m = 12'(q) * 12'(DECIMAL_BASE);
    return m == 12'(v);
  endfunction

endpackage

// ----- rtl/oahi_ram.sv -----
module oahi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/oahi_mod_unit.sv -----
module oahi_mod_unit #(
  parameter int DPW = 34
) (
  input  logic              clk,
  input  logic              rst_n,
  input  oahi_pkg::mod_req_t req,
  input  logic [DPW-1:0]    dividend,
  output oahi_pkg::mod_rsp_t rsp
);
  import oahi_pkg::*;

  localparam int ITERS = DPW / 2;
  localparam int CW    = $clog2(ITERS);

  logic           active_r;
  logic           done_r;
  logic [CW-1:0]  cnt_r;
  logic [7:0]     rem_r;
  logic [7:0]     div_r;
  logic [DPW-1:0] dvd_r;

  logic [8:0] t1, r1, t2, r2;

  // two restoring remainder steps per cycle
  always_comb begin
    t1 = {rem_r, dvd_r[DPW-1]};
    r1 = (t1 >= {1'b0, div_r}) ? t1 - {1'b0, div_r} : t1;
    t2 = {r1[7:0], dvd_r[DPW-2]};
    r2 = (t2 >= {1'b0, div_r}) ? t2 - {1'b0, div_r} : t2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        active_r <= 1'b1;
        cnt_r    <= req.short_op ? CW'(SHORT_ITERS - 1) : CW'(ITERS - 1);
        rem_r    <= 8'd0;
        div_r    <= req.divisor;
        dvd_r    <= req.short_op ? {dividend[7:0], {(DPW-8){1'b0}}} : dividend;
      end else if (active_r) begin
        rem_r <= r2[7:0];
        dvd_r <= dvd_r << 2;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ----- rtl/open_addressing_hash_insert_core.sv -----
// Open-addressing hash table, fixed-step probing.
// Command port: an operation transfers when start is high and busy is low.
// operation 0 clears all slots and derives the probe step, 1 inserts in_key,
// 2 reads slot in_slot. One result per operation on the out_ ports, marked
// by a one-cycle out_valid strobe; the receiver cannot stall and busy has
// already fallen in the strobe cycle, so the next command may follow.
// Config writes (cfg_we, cfg_index, cfg_wdata) are taken when cfg_we is high;
// the user must make them only while idle, the block does not enforce this.
// A read of a used slot waits for the key RAM. An insert finds the home-slot
// remainder, then the step remainder, then probes from the home slot until a
// free slot, a matching key or a full table. Clear of a table over 20 slots
// walks step candidates down from size/10 - 1, testing each and running
// Euclid rounds in the shared radix-4 remainder unit.
// Reset empties the table, size 255, hash_seed 1, probe step 1.
module open_addressing_hash_insert_core #(
  parameter int MAX_SLOTS = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_key,
  input  logic [7:0]  in_slot,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [7:0]  out_slot_index,
  output logic [7:0]  out_probe_count,
  output logic [31:0] out_slot_key,
  output logic        out_slot_valid,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import oahi_pkg::*;

  localparam int IDX_W    = $clog2(MAX_SLOTS);
  localparam int KEY_BITS = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
  localparam int DW       = KEY_BITS + 1;
  localparam int DPW      = ((DW + 1) / 2) * 2;

  state_t state_r, state_nxt;

  logic [7:0]          slot_cnt_r, hash_seed_r;
  logic [7:0]          probe_step_r, probe_step_nxt;
  logic [MAX_SLOTS-1:0] used_r;
  logic                used_clr, used_set;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [IDX_W-1:0]    home_r, home_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic [7:0]          step_r, step_nxt;
  logic [7:0]          tried_r, tried_nxt;
  logic [7:0]          cand_r, cand_nxt;
  logic [7:0]          gx_r, gx_nxt, gy_r, gy_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [7:0]  out_idx_r, out_idx_nxt;
  logic [7:0]  out_probe_r, out_probe_nxt;
  logic [31:0] out_key_r, out_key_nxt;
  logic        out_skv_r, out_skv_nxt;

  logic [7:0]          n_eff;
  logic [KEY_BITS-1:0] key_m;
  logic [DW-1:0]       hash_sum;
  logic [DPW-1:0]      mod_dvd;
  mod_req_t            mod_req;
  mod_rsp_t            mod_rsp;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_raddr;
  logic [KEY_BITS-1:0] ram_rdata;

  logic       acc, rd_in_range, slot_empty, key_hit, last_try;
  logic       m10, g_finish, g_next;
  logic [8:0] pos_sum;
  logic [7:0] n_div10;

  assign n_eff = ({1'b0, slot_cnt_r} > 9'(MAX_SLOTS)) ? 8'(MAX_SLOTS) : slot_cnt_r;
  assign key_m    = KEY_BITS'(in_key);
  assign hash_sum = DW'(key_m) + DW'(hash_seed_r);
  assign busy     = (state_r != S_IDLE);
  assign acc      = start && !busy;

  assign rd_in_range = in_slot < n_eff;
  assign slot_empty  = !used_r[pos_r];
  assign key_hit     = (ram_rdata == key_r);
  assign last_try    = (8'(tried_r + 8'd1) == n_eff);
  assign pos_sum     = 9'(pos_r) + 9'(step_r);
  assign n_div10     = div10(n_eff);

  assign m10      = is_mult10(cand_r);
  assign g_finish = (cand_r <= 8'd1) || (!m10 && gy_r == 8'd0 && gx_r <= 8'd1);
  assign g_next   = !g_finish && (m10 || gy_r == 8'd0);

  assign ram_raddr = (state_r == S_IDLE) ? in_slot[IDX_W-1:0] : pos_r;

  always_comb begin
    mod_dvd = DPW'(hash_sum);
    if (state_r == S_HASH) begin
      mod_dvd = DPW'(probe_step_r);
    end else if (state_r == S_GCD_TEST) begin
      mod_dvd = DPW'(gx_r);
    end
  end

  oahi_mod_unit #(.DPW(DPW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mod_req),
    .dividend (mod_dvd),
    .rsp      (mod_rsp)
  );

  oahi_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_SLOTS)) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata (key_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (in_operation)
            OP_CLEAR:  if (n_eff > STEP_MID_MAX) state_nxt = S_GCD_TEST;
            OP_INSERT: if (n_eff != 8'd0) state_nxt = S_HASH;
            OP_READ: begin
              if (rd_in_range && used_r[in_slot[IDX_W-1:0]]) state_nxt = S_RD_WAIT;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_HASH:    if (mod_rsp.done) state_nxt = S_STEPMOD;
      S_STEPMOD: if (mod_rsp.done) state_nxt = S_PROBE;
      S_PROBE:   state_nxt = slot_empty ? S_IDLE : S_CMP;
      S_CMP:     state_nxt = (key_hit || last_try) ? S_IDLE : S_PROBE;
      S_RD_WAIT: state_nxt = S_IDLE;
      S_GCD_TEST: begin
        if (g_finish) begin
          state_nxt = S_IDLE;
        end else if (!g_next) begin
          state_nxt = S_GCD;
        end
      end
      S_GCD:     if (mod_rsp.done) state_nxt = S_GCD_TEST;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    probe_step_nxt = probe_step_r;
    key_nxt        = key_r;
    home_nxt       = home_r;
    pos_nxt        = pos_r;
    step_nxt       = step_r;
    tried_nxt      = tried_r;
    cand_nxt       = cand_r;
    gx_nxt         = gx_r;
    gy_nxt         = gy_r;
    used_clr       = 1'b0;
    used_set       = 1'b0;
    ram_we         = 1'b0;
    mod_req        = '0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_probe_nxt  = out_probe_r;
    out_key_nxt    = out_key_r;
    out_skv_nxt    = out_skv_r;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          out_status_nxt = STAT_OK;
          out_idx_nxt    = 8'd0;
          out_probe_nxt  = 8'd0;
          out_key_nxt    = 32'd0;
          out_skv_nxt    = 1'b0;
          unique case (in_operation)
            OP_CLEAR: begin
              used_clr = 1'b1;
              if (n_eff <= STEP_SMALL_MAX) begin
                probe_step_nxt = 8'd1;
                out_valid_nxt  = 1'b1;
              end else if (n_eff <= STEP_MID_MAX) begin
                if (n_eff == STEP_ODD_A || n_eff == STEP_ODD_B) begin
                  probe_step_nxt = STEP_ODD_VAL;
                end else begin
                  probe_step_nxt = 8'((9'(n_eff) + 9'd1) >> 1) - 8'd1;
                end
                out_valid_nxt = 1'b1;
              end else begin
                cand_nxt = n_div10 - 8'd1;
                gx_nxt   = n_eff;
                gy_nxt   = n_div10 - 8'd1;
              end
            end
            OP_INSERT: begin
              key_nxt = key_m;
              if (n_eff == 8'd0) begin
                out_status_nxt = STAT_FULL;
                out_valid_nxt  = 1'b1;
              end else begin
                mod_req.start    = 1'b1;
                mod_req.short_op = 1'b0;
                mod_req.divisor  = n_eff;
              end
            end
            OP_READ: begin
              out_idx_nxt = in_slot;
              if (!rd_in_range) begin
                out_status_nxt = STAT_RANGE;
                out_valid_nxt  = 1'b1;
              end else if (!used_r[in_slot[IDX_W-1:0]]) begin
                out_valid_nxt = 1'b1;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      S_HASH: begin
        if (mod_rsp.done) begin
          home_nxt         = IDX_W'(mod_rsp.rem);
          mod_req.start    = 1'b1;
          mod_req.short_op = 1'b1;
          mod_req.divisor  = n_eff;
        end
      end
      S_STEPMOD: begin
        if (mod_rsp.done) begin
          step_nxt  = mod_rsp.rem;
          pos_nxt   = home_r;
          tried_nxt = 8'd0;
        end
      end
      S_PROBE: begin
        if (slot_empty) begin
          ram_we         = 1'b1;
          used_set       = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_idx_nxt    = 8'(pos_r);
          out_probe_nxt  = tried_r;
        end
      end
      S_CMP: begin
        if (key_hit) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_DUP;
          out_idx_nxt    = 8'(pos_r);
          out_probe_nxt  = tried_r;
        end else if (last_try) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_FULL;
          out_idx_nxt    = 8'(home_r);
          out_probe_nxt  = n_eff;
        end else begin
          tried_nxt = tried_r + 8'd1;
          pos_nxt   = (pos_sum >= 9'(n_eff)) ? IDX_W'(pos_sum - 9'(n_eff))
                                             : IDX_W'(pos_sum);
        end
      end
      S_RD_WAIT: begin
        out_valid_nxt = 1'b1;
        out_key_nxt   = 32'(ram_rdata);
        out_skv_nxt   = 1'b1;
      end
      S_GCD_TEST: begin
        if (g_finish) begin
          probe_step_nxt = cand_r;
          out_valid_nxt  = 1'b1;
        end else if (g_next) begin
          cand_nxt = cand_r - 8'd1;
          gx_nxt   = n_eff;
          gy_nxt   = cand_r - 8'd1;
        end else begin
          mod_req.start    = 1'b1;
          mod_req.short_op = 1'b1;
          mod_req.divisor  = gy_r;
        end
      end
      S_GCD: begin
        if (mod_rsp.done) begin
          gx_nxt = gy_r;
          gy_nxt = mod_rsp.rem;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_cnt_r   <= SLOT_COUNT_RST;
      hash_seed_r  <= HASH_SEED_RST;
      probe_step_r <= PROBE_STEP_RST;
      used_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      probe_step_r <= probe_step_nxt;
      out_valid_r  <= out_valid_nxt;
      if (used_clr) begin
        used_r <= '0;
      end else if (used_set) begin
        used_r[pos_r] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SLOT_COUNT: slot_cnt_r  <= cfg_wdata;
          CFG_HASH_SEED:  hash_seed_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    home_r       <= home_nxt;
    pos_r        <= pos_nxt;
    step_r       <= step_nxt;
    tried_r      <= tried_nxt;
    cand_r       <= cand_nxt;
    gx_r         <= gx_nxt;
    gy_r         <= gy_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_probe_r  <= out_probe_nxt;
    out_key_r    <= out_key_nxt;
    out_skv_r    <= out_skv_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_index  = out_idx_r;
  assign out_probe_count = out_probe_r;
  assign out_slot_key    = out_key_r;
  assign out_slot_valid  = out_skv_r;

`ifndef ASSERT_OFF
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  a_cmd_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid)) else $error("command transfer lost");

  a_write_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !used_r[pos_r]) else $error("key written over occupied slot");

  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (9'(pos_r) < 9'(n_eff))) else $error("probe beyond table");

  a_mod_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> (state_r == S_HASH || state_r == S_STEPMOD || state_r == S_GCD))
    else $error("remainder result with no waiter");
`endif

endmodule
